FILE: hdl/wjb_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and fixed-point helpers of the weighted joint bend core.
package wjb_pkg;

  typedef struct packed {
    logic signed [31:0] vert_x;
    logic signed [31:0] vert_y;
    logic signed [31:0] vert_z;
    logic signed [31:0] pivot_height;
    logic signed [31:0] bend_angle;
    logic signed [31:0] axis_angle;
    logic               upper_half;
  } wjb_in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
  } wjb_out_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [32:0] py;
    logic signed [31:0] pz;
    logic signed [31:0] vy;
    logic signed [31:0] pivot;
    logic               bypass;
  } wjb_side_t;

  localparam logic [31:0]        BEND_MIN     = 32'd168;
  localparam logic signed [33:0] W_HALF_ONE   = 34'sd65536;
  localparam logic signed [33:0] W_TWO        = 34'sd131072;
  localparam logic [38:0]        Q30_TWO_PI   = 39'd6746518852;
  localparam logic signed [34:0] Q30_PI       = 35'sd3373259426;
  localparam logic signed [34:0] Q30_TWO_PI_S = 35'sd6746518852;
  localparam logic signed [34:0] Q30_HALF_PI  = 35'sd1686629713;
  localparam logic signed [33:0] CORDIC_GAIN  = 34'sd652032874;
  localparam logic signed [32:0] Q30_ONE      = 33'sd1073741824;
  localparam int                 CORDIC_STEPS = 30;
  localparam int                 RED_STEPS    = 6;
  localparam int                 SC_LAT       = RED_STEPS + CORDIC_STEPS + 4;
  localparam int                 FRONT_LAT    = 2;
  localparam int                 ROT_LAT      = 5;

  function automatic logic [29:0] atan_q30(input int i);
    logic [29:0] a;
    case (i)
      0: a = 30'd843314856;
      1: a = 30'd497837829;
      2: a = 30'd263043836;
      3: a = 30'd133525158;
      4: a = 30'd67021686;
      5: a = 30'd33543515;
      6: a = 30'd16775850;
      7: a = 30'd8388437;
      8: a = 30'd4194282;
      9: a = 30'd2097149;
      10: a = 30'd1048575;
      11: a = 30'd524287;
      12: a = 30'd262143;
      13: a = 30'd131071;
      14: a = 30'd65535;
      15: a = 30'd32767;
      16: a = 30'd16383;
      17: a = 30'd8191;
      18: a = 30'd4095;
      19: a = 30'd2047;
      20: a = 30'd1023;
      21: a = 30'd511;
      22: a = 30'd255;
      23: a = 30'd127;
      24: a = 30'd63;
      25: a = 30'd31;
      26: a = 30'd15;
      27: a = 30'd7;
      28: a = 30'd3;
      29: a = 30'd1;
      default: a = 30'd0;
    endcase
    return a;
  endfunction

  // Product with a Q.30 factor, rounded to nearest with ties away from zero.
  function automatic logic signed [37:0] fxm(input logic signed [35:0] v,
                                             input logic signed [33:0] t);
    logic [35:0] u;
    logic [33:0] w;
    logic [69:0] p;
    logic [37:0] r;
    logic        neg;
    neg = v[35] ^ t[33];
    u = v[35] ? 36'(-v) : 36'(v);
    w = t[33] ? 34'(-t) : 34'(t);
    p = 70'(u) * 70'(w) + (70'(1) << 29);
    r = p[67:30];
    return neg ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -40'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

FILE: hdl/wjb_front.sv
`timescale 1ns / 1ps
// Front stages: pivot distance, bend weight and the scaled bend angle.
module wjb_front import wjb_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  wjb_in_t            in_i,
  output logic               valid_o,
  output logic signed [32:0] theta_o,
  output logic signed [31:0] axis_o,
  output wjb_side_t          side_o
);

  logic               v1_q, v2_q;
  logic [31:0]        absb_d, absb1_q;
  logic               neg1_q;
  logic [16:0]        w_d, w1_q;
  logic signed [31:0] axis1_q, axis2_q;
  wjb_side_t          side_d, side1_q, side2_q;
  logic signed [32:0] py;
  logic signed [33:0] t;
  logic [48:0]        prod;
  logic [31:0]        mag;
  logic signed [32:0] theta_d, theta2_q;

  always_comb begin
    absb_d = in_i.bend_angle[31] ? 32'(-in_i.bend_angle) : 32'(in_i.bend_angle);
    py = 33'(in_i.vert_y) - 33'(in_i.pivot_height);
    t = W_HALF_ONE + (in_i.upper_half ? 34'(py) : -34'(py));
    if (t <= 34'sd0) begin
      w_d = 17'd0;
    end else if (t >= W_TWO) begin
      w_d = 17'd65536;
    end else begin
      w_d = 17'(t[17:1]);
    end
    side_d.px = in_i.vert_x;
    side_d.py = py;
    side_d.pz = in_i.vert_z;
    side_d.vy = in_i.vert_y;
    side_d.pivot = in_i.pivot_height;
    side_d.bypass = absb_d < BEND_MIN;
  end

  always_comb begin
    prod = 49'(absb1_q) * 49'(w1_q) + 49'd32768;
    mag = prod[47:16];
    theta_d = neg1_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    absb1_q <= absb_d;
    neg1_q <= in_i.bend_angle[31];
    w1_q <= w_d;
    axis1_q <= in_i.axis_angle;
    side1_q <= side_d;
    theta2_q <= theta_d;
    axis2_q <= axis1_q;
    side2_q <= side1_q;
  end

  assign valid_o = v2_q;
  assign theta_o = theta2_q;
  assign axis_o = axis2_q;
  assign side_o = side2_q;

endmodule

FILE: hdl/wjb_sincos.sv
`timescale 1ns / 1ps
// Pipelined range reduction and 30-step CORDIC giving sine and cosine in Q.30.
module wjb_sincos import wjb_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic signed [32:0] ang_i,
  output logic               valid_o,
  output logic signed [31:0] sin_o,
  output logic signed [31:0] cos_o
);

  logic [38:0]        m_q   [0:RED_STEPS];
  logic               neg_q [0:RED_STEPS];
  logic               rv_q  [0:RED_STEPS];
  logic signed [34:0] r_d, r_q, rf_d;
  logic               nv_q, fv_q, flipf_d;
  logic signed [33:0] x_q   [0:CORDIC_STEPS];
  logic signed [33:0] y_q   [0:CORDIC_STEPS];
  logic signed [33:0] z_q   [0:CORDIC_STEPS];
  logic               cf_q  [0:CORDIC_STEPS];
  logic               cv_q  [0:CORDIC_STEPS];
  logic               ov_q;
  logic signed [31:0] sin_q, cos_q;
  logic [32:0]        abs_ang;

  assign abs_ang = ang_i[32] ? 33'(-ang_i) : 33'(ang_i);

  always_ff @(posedge clk_i) begin
    m_q[0] <= {abs_ang, 6'b0};
    neg_q[0] <= ang_i[32];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q[0] <= 1'b0;
    end else begin
      rv_q[0] <= valid_i;
    end
  end

  for (genvar k = 0; k < RED_STEPS; k++) begin : g_red
    localparam logic [38:0] SUB = Q30_TWO_PI << (RED_STEPS - 1 - k);
    always_ff @(posedge clk_i) begin
      m_q[k+1] <= (m_q[k] >= SUB) ? m_q[k] - SUB : m_q[k];
      neg_q[k+1] <= neg_q[k];
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rv_q[k+1] <= 1'b0;
      end else begin
        rv_q[k+1] <= rv_q[k];
      end
    end
  end

  always_comb begin
    logic signed [34:0] mm;
    mm = $signed({1'b0, m_q[RED_STEPS][33:0]});
    if (mm > Q30_PI) begin
      mm = mm - Q30_TWO_PI_S;
    end
    r_d = neg_q[RED_STEPS] ? -mm : mm;
  end

  always_comb begin
    rf_d = r_q;
    flipf_d = 1'b0;
    if (r_q > Q30_HALF_PI) begin
      rf_d = Q30_PI - r_q;
      flipf_d = 1'b1;
    end else if (r_q < -Q30_HALF_PI) begin
      rf_d = -Q30_PI - r_q;
      flipf_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
    x_q[0] <= CORDIC_GAIN;
    y_q[0] <= 34'sd0;
    z_q[0] <= rf_d[33:0];
    cf_q[0] <= flipf_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nv_q <= 1'b0;
      fv_q <= 1'b0;
    end else begin
      nv_q <= rv_q[RED_STEPS];
      fv_q <= nv_q;
    end
  end

  assign cv_q[0] = fv_q;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    localparam logic signed [33:0] ATAN = $signed({4'b0, atan_q30(i)});
    logic signed [33:0] dx, dy;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      if (!z_q[i][33]) begin
        x_q[i+1] <= x_q[i] - dx;
        y_q[i+1] <= y_q[i] + dy;
        z_q[i+1] <= z_q[i] - ATAN;
      end else begin
        x_q[i+1] <= x_q[i] + dx;
        y_q[i+1] <= y_q[i] - dy;
        z_q[i+1] <= z_q[i] + ATAN;
      end
      cf_q[i+1] <= cf_q[i];
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cv_q[i+1] <= 1'b0;
      end else begin
        cv_q[i+1] <= cv_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sin_q <= y_q[CORDIC_STEPS][31:0];
    cos_q <= cf_q[CORDIC_STEPS] ? 32'(-x_q[CORDIC_STEPS]) : x_q[CORDIC_STEPS][31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else begin
      ov_q <= cv_q[CORDIC_STEPS];
    end
  end

  assign valid_o = ov_q;
  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

FILE: hdl/wjb_rotate.sv
`timescale 1ns / 1ps
// Multiplier stages of the axis-angle rotation with saturation and small-bend bypass.
module wjb_rotate import wjb_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  wjb_side_t          side_i,
  input  logic signed [31:0] s_i,
  input  logic signed [31:0] c_i,
  input  logic signed [31:0] sa_i,
  input  logic signed [31:0] ca_i,
  output logic               valid_o,
  output wjb_out_t           out_o
);

  logic [ROT_LAT-1:0] v_q;
  wjb_side_t          sd1_q, sd2_q, sd3_q, sd4_q;
  logic signed [31:0] s1_q, s2_q;
  logic signed [31:0] sa1_q, sa2_q, sa3_q, ca1_q, ca2_q, ca3_q;
  logic signed [32:0] omc1_q, omc2_q;
  logic signed [37:0] pxc1_q, pyc1_q, pzc1_q, pxca1_q, pzsa1_q, pxsa1_q, pzca1_q;
  logic signed [37:0] pysa1_q, pyca1_q;
  logic signed [37:0] pxc2_q, pyc2_q, pzc2_q, pysa2_q, pyca2_q;
  logic signed [37:0] d2_q, q2_q;
  logic signed [37:0] pxc3_q, pyc3_q, pzc3_q, e3_q, qs3_q, pys3_q, pycs3_q;
  logic signed [37:0] pxc4_q, pyc4_q, pzc4_q, qs4_q, pys4_q, pycs4_q, ex4_q, ez4_q;
  wjb_out_t           out_d, out_q;

  always_ff @(posedge clk_i) begin
    sd1_q <= side_i;
    s1_q <= s_i;
    sa1_q <= sa_i;
    ca1_q <= ca_i;
    omc1_q <= Q30_ONE - 33'(c_i);
    pxc1_q <= fxm(36'(side_i.px), 34'(c_i));
    pyc1_q <= fxm(36'(side_i.py), 34'(c_i));
    pzc1_q <= fxm(36'(side_i.pz), 34'(c_i));
    pxca1_q <= fxm(36'(side_i.px), 34'(ca_i));
    pzsa1_q <= fxm(36'(side_i.pz), 34'(sa_i));
    pxsa1_q <= fxm(36'(side_i.px), 34'(sa_i));
    pzca1_q <= fxm(36'(side_i.pz), 34'(ca_i));
    pysa1_q <= fxm(36'(side_i.py), 34'(sa_i));
    pyca1_q <= fxm(36'(side_i.py), 34'(ca_i));

    sd2_q <= sd1_q;
    s2_q <= s1_q;
    sa2_q <= sa1_q;
    ca2_q <= ca1_q;
    omc2_q <= omc1_q;
    pxc2_q <= pxc1_q;
    pyc2_q <= pyc1_q;
    pzc2_q <= pzc1_q;
    pysa2_q <= pysa1_q;
    pyca2_q <= pyca1_q;
    d2_q <= pxca1_q + pzsa1_q;
    q2_q <= pxsa1_q - pzca1_q;

    sd3_q <= sd2_q;
    sa3_q <= sa2_q;
    ca3_q <= ca2_q;
    pxc3_q <= pxc2_q;
    pyc3_q <= pyc2_q;
    pzc3_q <= pzc2_q;
    e3_q <= fxm(36'(d2_q), 34'(omc2_q));
    qs3_q <= fxm(36'(q2_q), 34'(s2_q));
    pys3_q <= fxm(36'(pysa2_q), 34'(s2_q));
    pycs3_q <= fxm(36'(pyca2_q), 34'(s2_q));

    sd4_q <= sd3_q;
    pxc4_q <= pxc3_q;
    pyc4_q <= pyc3_q;
    pzc4_q <= pzc3_q;
    qs4_q <= qs3_q;
    pys4_q <= pys3_q;
    pycs4_q <= pycs3_q;
    ex4_q <= fxm(36'(e3_q), 34'(ca3_q));
    ez4_q <= fxm(36'(e3_q), 34'(sa3_q));

    out_q <= out_d;
  end

  always_comb begin
    if (sd4_q.bypass) begin
      out_d.out_x = sd4_q.px;
      out_d.out_y = sd4_q.vy;
      out_d.out_z = sd4_q.pz;
    end else begin
      out_d.out_x = sat32(40'(pxc4_q) - 40'(pys4_q) + 40'(ex4_q));
      out_d.out_y = sat32(40'(pyc4_q) + 40'(qs4_q) + 40'(sd4_q.pivot));
      out_d.out_z = sat32(40'(pzc4_q) + 40'(pycs4_q) + 40'(ez4_q));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[ROT_LAT-2:0], valid_i};
    end
  end

  assign valid_o = v_q[ROT_LAT-1];
  assign out_o = out_q;

endmodule

FILE: hdl/weighted_joint_bend_rotation_core.sv
`timescale 1ns / 1ps
// Top level of the weighted joint bend vertex rotation pipeline.
//
//   Channel   Handshake           Payload       Direction
//   input     start_i / busy_o    in_i          in
//   result    valid_o (strobe)    out_o         out
//
// A new word is taken in every cycle; busy_o stays low.
// Each word passes, in order, through two front stages, forty
// stages of range reduction and CORDIC, and five multiplier stages.
// Reset clears only the valid bits of the pipeline; no result is pending after it.
// The receiver cannot stall, so the pipeline never holds.
module weighted_joint_bend_rotation_core import wjb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  output logic     busy_o,
  input  wjb_in_t  in_i,
  output logic     valid_o,
  output wjb_out_t out_o
);

  localparam int TOTAL_LAT = FRONT_LAT + SC_LAT + ROT_LAT;

  logic               fr_valid;
  logic signed [32:0] fr_theta;
  logic signed [31:0] fr_axis;
  wjb_side_t          fr_side;
  logic               sc_valid, ax_valid;
  logic signed [31:0] sin_t, cos_t, sin_a, cos_a;
  wjb_side_t          side_q [0:SC_LAT-1];

  assign busy_o = 1'b0;

  wjb_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i),
    .in_i    (in_i),
    .valid_o (fr_valid),
    .theta_o (fr_theta),
    .axis_o  (fr_axis),
    .side_o  (fr_side)
  );

  wjb_sincos u_sc_bend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fr_valid),
    .ang_i   (fr_theta),
    .valid_o (sc_valid),
    .sin_o   (sin_t),
    .cos_o   (cos_t)
  );

  wjb_sincos u_sc_axis (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fr_valid),
    .ang_i   (33'(fr_axis)),
    .valid_o (ax_valid),
    .sin_o   (sin_a),
    .cos_o   (cos_a)
  );

  always_ff @(posedge clk_i) begin
    side_q[0] <= fr_side;
    for (int i = 1; i < SC_LAT; i++) begin
      side_q[i] <= side_q[i-1];
    end
  end

  wjb_rotate u_rotate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sc_valid),
    .side_i  (side_q[SC_LAT-1]),
    .s_i     (sin_t),
    .c_i     (cos_t),
    .sa_i    (sin_a),
    .ca_i    (cos_a),
    .valid_o (valid_o),
    .out_o   (out_o)
  );

  a_sc_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sc_valid == ax_valid)
    else $error("Bend and axis sine units are out of step.");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##TOTAL_LAT valid_o)
    else $error("A word did not produce its result on time.");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !start_i |-> ##TOTAL_LAT !valid_o)
    else $error("A result appeared without a word.");

endmodule
